// ===== rtl/core/nested_activity_time_accounting_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Nested activity time accounting - assertion macros
// Shared assertion shorthands. Each use samples on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NESTED_ACTIVITY_TIME_ACCOUNTING_UNIT_DEFINES_SVH
`define NESTED_ACTIVITY_TIME_ACCOUNTING_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/nat_pkg.sv =====
// ----------------------------------------------------------------------------
// nat_pkg
// Types and constants shared by the activity time accounting modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nat_pkg;

  localparam int unsigned CAT_W   = 5;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned TICK_W  = 64;

  localparam logic [CAT_W-1:0]   CAT_TOTAL = 5'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [TICK_W-1:0]  last_ts;
    logic [TICK_W-1:0]  busy;
    logic [TICK_W-1:0]  wgt;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [DEPTH_W-1:0] depth;
    logic [TICK_W-1:0]  busy;
    logic [TICK_W-1:0]  wgt;
  } res_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/nested_activity_time_accounting_unit.sv =====
// ----------------------------------------------------------------------------
// nested_activity_time_accounting_unit
// Per-category nested busy-time and depth-weighted time counters, driven by
// start, stop and read events.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Bus    Fields (lowest bit first)
//  -------  ---  -----  ---------------------------------------------------
//  s_axis   in   tuser  action[1:0]
//                tdata  category[4:0], timestamp[68:5], zero fill [71:69]
//  m_axis   out  tuser  status[1:0]
//                tdata  depth_now[7:0], busy_ticks[71:8],
//                       weighted_ticks[135:72]
//
//  Per event: a category out of range goes straight to the result, a read or a
//  refused event reads its entry once, and a start or stop reads and checks the
//  depth of each touched category (two or three of them), then updates each one
//  through the single shared 64-bit add/subtract/multiply unit, in the order
//  subtract, add, multiply, add.
//  Reset clears the sequencer, the output valid flag and the per-entry valid
//  bits at once; no clearing pass runs, unwritten entries read as zero.
//  A result waiting on m_axis does not block the next accept; only a second
//  finished result waits in the sequencer until the output register is free.
//
`default_nettype none

module nested_activity_time_accounting_unit #(
  parameter int NUM_CATEGORIES = 22
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,   // category[4:0], timestamp[68:5]
  input  wire logic [1:0]   s_axis_tuser,   // action[1:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [135:0]      m_axis_tdata,   // depth_now, busy_ticks, weighted_ticks
  output logic [1:0]        m_axis_tuser    // status[1:0]
);
  import nat_pkg::*;

  localparam int CatW = $clog2(NUM_CATEGORIES);

  // Link between sequencer, store and arithmetic unit.
  mem_ctl_t            mem_ctl;
  logic [CatW-1:0]     rd_addr;
  logic [CatW-1:0]     wr_addr;
  entry_t              wr_data;
  entry_t              rd_data;
  alu_op_e             alu_op;
  logic [TICK_W-1:0]   alu_a;
  logic [TICK_W-1:0]   alu_b;
  logic [TICK_W-1:0]   alu_y;

  // Output register stage.
  logic                out_valid_q;
  res_t                out_q;
  logic                out_free;
  logic                done;
  res_t                res;

  assign out_free = !out_valid_q || m_axis_tready;

  nat_seq #(
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[1:0]),
    .category_i  (s_axis_tdata[4:0]),
    .timestamp_i (s_axis_tdata[68:5]),
    .out_free_i  (out_free),
    .done_o      (done),
    .res_o       (res),
    .ctl_o       (mem_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_data_i   (rd_data),
    .alu_op_o    (alu_op),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_y_i     (alu_y)
  );

  nat_store #(
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  nat_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  // Load a finished result, or drop the held one once its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload: hold while waiting, no reset needed.
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.wgt, out_q.busy, out_q.depth};

endmodule

`default_nettype wire

// ===== rtl/core/nat_store.sv =====
// ----------------------------------------------------------------------------
// nat_store
// Per-category counter memory: one read and one write port, registered
// read data, and a valid bit per entry so unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_store #(
  parameter int NUM_CATEGORIES = 22,
  localparam int CatW = $clog2(NUM_CATEGORIES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nat_pkg::mem_ctl_t ctl_i,
  input  wire logic [CatW-1:0]   rd_addr_i,
  input  wire logic [CatW-1:0]   wr_addr_i,
  input  wire nat_pkg::entry_t   wr_data_i,
  output nat_pkg::entry_t        rd_data_o
);
  import nat_pkg::*;

  entry_t                    mem [NUM_CATEGORIES];
  logic [NUM_CATEGORIES-1:0] valid_q;
  entry_t                    rd_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as zero through their cleared valid bit.
  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/nat_alu.sv =====
// ----------------------------------------------------------------------------
// nat_alu
// Shared 64-bit arithmetic unit: add, subtract, or multiply by a depth.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_alu (
  input  wire nat_pkg::alu_op_e              op_i,
  input  wire logic [nat_pkg::TICK_W-1:0]    a_i,
  input  wire logic [nat_pkg::TICK_W-1:0]    b_i,
  output logic [nat_pkg::TICK_W-1:0]         y_o
);
  import nat_pkg::*;

  logic [TICK_W-1:0] depth_ext;
  logic [TICK_W-1:0] prod;

  // Low byte of b carries the depth, upper bits held at zero; keep the
  // product modulo 2^64.
  assign depth_ext = {{(TICK_W-DEPTH_W){1'b0}}, b_i[DEPTH_W-1:0]};
  assign prod      = a_i * depth_ext;

  always_comb begin
    case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      ALU_MUL: y_o = prod;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/nat_seq.sv =====
// ----------------------------------------------------------------------------
// nat_seq
// Event sequencer: checks the depths of every category a start or stop
// touches, then charges and moves each one through the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nested_activity_time_accounting_unit_defines.svh"

module nat_seq #(
  parameter int NUM_CATEGORIES = 22,
  localparam int CatW = $clog2(NUM_CATEGORIES)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [nat_pkg::CAT_W-1:0]     category_i,
  input  wire logic [nat_pkg::TICK_W-1:0]    timestamp_i,
  input  wire logic                          out_free_i,
  output logic                               done_o,
  output nat_pkg::res_t                      res_o,
  output nat_pkg::mem_ctl_t                  ctl_o,
  output logic [CatW-1:0]                    rd_addr_o,
  output logic [CatW-1:0]                    wr_addr_o,
  output nat_pkg::entry_t                    wr_data_o,
  input  wire nat_pkg::entry_t               rd_data_i,
  output nat_pkg::alu_op_e                   alu_op_o,
  output logic [nat_pkg::TICK_W-1:0]         alu_a_o,
  output logic [nat_pkg::TICK_W-1:0]         alu_b_o,
  input  wire logic [nat_pkg::TICK_W-1:0]    alu_y_i
);
  import nat_pkg::*;

  localparam logic [6:0]      NumCat   = 7'(NUM_CATEGORIES);
  localparam logic [6:0]      UnivCat  = 7'(NUM_CATEGORIES - 1);
  localparam logic [CatW-1:0] UnivIdx  = CatW'(NUM_CATEGORIES - 1);
  localparam logic [CatW-1:0] TotalIdx = CatW'(CAT_TOTAL);
  localparam bit              SplitAgg = (NUM_CATEGORIES - 1) != 2;

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CCK, S_URD, S_UEL, S_UBUSY, S_UMUL, S_UWGT, S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic                start_q, start_d;
  logic                upd_q, upd_d;
  status_e             stat_q, stat_d;
  logic [TICK_W-1:0]   ts_q, ts_d;
  logic [CatW-1:0]     tgt_q [3];
  logic [CatW-1:0]     tgt_d [3];
  logic [1:0]          last_idx_q, last_idx_d;
  logic [1:0]          idx_q, idx_d;
  logic [TICK_W-1:0]   el_q, el_d;
  logic [TICK_W-1:0]   busy_q, busy_d;
  logic [TICK_W-1:0]   prod_q, prod_d;
  res_t                res_q, res_d;

  logic                cat_ok;
  logic                is_agg;
  logic                below_total;
  logic                is_move;
  logic                bad_depth;
  logic [DEPTH_W-1:0]  depth_next;

  assign cat_ok      = {2'b00, category_i} < NumCat;
  assign is_agg      = (category_i == CAT_TOTAL) || ({2'b00, category_i} == UnivCat);
  assign below_total = category_i < CAT_TOTAL;
  assign is_move     = (action_i == ACT_START) || (action_i == ACT_STOP);
  assign bad_depth   = start_q ? (rd_data_i.depth == DEPTH_MAX)
                               : (rd_data_i.depth == '0);
  assign depth_next  = start_q ? rd_data_i.depth + 8'd1 : rd_data_i.depth - 8'd1;

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_FIN) && out_free_i;
  assign res_o      = res_q;
  assign rd_addr_o  = tgt_q[idx_q];
  assign wr_addr_o  = tgt_q[idx_q];

  always_comb begin
    wr_data_o.depth   = depth_next;
    wr_data_o.last_ts = ts_q;
    wr_data_o.busy    = busy_q;
    wr_data_o.wgt     = alu_y_i;
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_op_o = ALU_ADD;
    alu_a_o  = '0;
    alu_b_o  = '0;
    case (state_q)
      S_UEL: begin
        alu_op_o = ALU_SUB;
        alu_a_o  = ts_q;
        alu_b_o  = rd_data_i.last_ts;
      end
      S_UBUSY: begin
        alu_a_o = rd_data_i.busy;
        alu_b_o = el_q;
      end
      S_UMUL: begin
        alu_op_o = ALU_MUL;
        alu_a_o  = el_q;
        alu_b_o  = {{(TICK_W-DEPTH_W){1'b0}}, rd_data_i.depth};
      end
      S_UWGT: begin
        alu_a_o = rd_data_i.wgt;
        alu_b_o = prod_q;
      end
      default: begin
        alu_op_o = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    start_d    = start_q;
    upd_d      = upd_q;
    stat_d     = stat_q;
    ts_d       = ts_q;
    tgt_d      = tgt_q;
    last_idx_d = last_idx_q;
    idx_d      = idx_q;
    el_d       = el_q;
    busy_d     = busy_q;
    prod_d     = prod_q;
    res_d      = res_q;
    ctl_o      = '{rd: 1'b0, wr: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ts_d     = timestamp_i;
          start_d  = (action_i == ACT_START);
          idx_d    = 2'd0;
          tgt_d[0] = CatW'(category_i);
          if (below_total && SplitAgg) begin
            tgt_d[1]   = TotalIdx;
            tgt_d[2]   = UnivIdx;
            last_idx_d = 2'd2;
          end else begin
            tgt_d[1]   = UnivIdx;
            tgt_d[2]   = UnivIdx;
            last_idx_d = 2'd1;
          end
          upd_d  = is_move && !is_agg;
          stat_d = (is_move && is_agg) ? ST_REFUSED : ST_OK;
          if (!cat_ok) begin
            res_d   = '{status: ST_REFUSED, depth: '0, busy: '0, wgt: '0};
            state_d = S_FIN;
          end else begin
            state_d = S_CRD;
          end
        end
      end
      S_CRD: begin
        ctl_o.rd = 1'b1;
        state_d  = S_CCK;
      end
      S_CCK: begin
        if (idx_q == 2'd0) begin
          res_d = '{status: stat_q, depth: rd_data_i.depth,
                    busy: rd_data_i.busy, wgt: rd_data_i.wgt};
        end
        if (!upd_q) begin
          state_d = S_FIN;
        end else if (bad_depth) begin
          res_d.status = start_q ? ST_OVERFLOW : ST_UNDERFLOW;
          state_d      = S_FIN;
        end else if (idx_q == last_idx_q) begin
          idx_d   = 2'd0;
          state_d = S_URD;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_CRD;
        end
      end
      S_URD: begin
        ctl_o.rd = 1'b1;
        state_d  = S_UEL;
      end
      S_UEL: begin
        // Idle time does not count.
        el_d    = (rd_data_i.depth != '0) ? alu_y_i : '0;
        state_d = S_UBUSY;
      end
      S_UBUSY: begin
        busy_d  = alu_y_i;
        state_d = S_UMUL;
      end
      S_UMUL: begin
        prod_d  = alu_y_i;
        state_d = S_UWGT;
      end
      S_UWGT: begin
        ctl_o.wr = 1'b1;
        if (idx_q == 2'd0) begin
          res_d = '{status: ST_OK, depth: depth_next, busy: busy_q, wgt: alu_y_i};
        end
        if (idx_q == last_idx_q) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_URD;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      start_q    <= 1'b0;
      upd_q      <= 1'b0;
      stat_q     <= ST_OK;
      ts_q       <= '0;
      tgt_q      <= '{default: '0};
      last_idx_q <= 2'd0;
      idx_q      <= 2'd0;
      el_q       <= '0;
      busy_q     <= '0;
      prod_q     <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      start_q    <= start_d;
      upd_q      <= upd_d;
      stat_q     <= stat_d;
      ts_q       <= ts_d;
      tgt_q      <= tgt_d;
      last_idx_q <= last_idx_d;
      idx_q      <= idx_d;
      el_q       <= el_d;
      busy_q     <= busy_d;
      prod_q     <= prod_d;
      res_q      <= res_d;
    end
  end

  `NAT_ASSERT_IMP(a_idx_in_list, (state_q != S_IDLE) && (state_q != S_FIN), idx_q <= last_idx_q, "target index past end of list")
  `NAT_ASSERT_IMP(a_start_step, ctl_o.wr && start_q, (rd_data_i.depth != DEPTH_MAX) && (wr_data_o.depth == rd_data_i.depth + 8'd1), "start write without a one-step depth rise")
  `NAT_ASSERT_IMP(a_stop_step, ctl_o.wr && !start_q, (rd_data_i.depth != '0) && (wr_data_o.depth == rd_data_i.depth - 8'd1), "stop write without a one-step depth fall")
  `NAT_ASSERT_NXT(a_err_ends_item, (state_q == S_CCK) && upd_q && bad_depth, (state_q == S_FIN) && !ctl_o.wr, "depth error did not end the event")

endmodule

`default_nettype wire

// ===== dv/tb_nested_activity_time_accounting_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_activity_time_accounting_unit
// Self-checking bench for the activity time accounting unit. Start, stop and
// read events go in on the slave stream. The bench keeps its own per-category
// depth, busy and weighted counters and checks every report on the master
// stream against them. Both streams idle in random bursts, and there is one
// long receiver hold-off and some full drains.
// ----------------------------------------------------------------------------
module tb_nested_activity_time_accounting_unit;
  import nat_pkg::*;

  localparam int               N_CAT       = 22;
  localparam logic [CAT_W-1:0] CAT_UNIV    = CAT_W'(N_CAT - 1);
  localparam logic [CAT_W-1:0] DEEP_CAT    = 5'd0;
  localparam logic [1:0]       ACT_READ    = 2'd2;
  localparam logic [1:0]       ACT_SPARE   = 2'd3;   // decoded as a read
  localparam int               N_EVENTS    = 1900;
  localparam int               TAIL_LEN    = 150;    // final events, no idling
  localparam int               HOLD_AT     = 300;    // reports before long hold-off
  localparam int               LONG_HOLD   = 400;
  localparam int               SETTLE_CYC  = 40;
  localparam int               CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic              drain;  // wait until every report is back before offering
    logic [1:0]        act;
    logic [CAT_W-1:0]  cat;
    logic [TICK_W-1:0] ts;
  } activity_evt_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata  = '0;   // category[4:0], timestamp[68:5], zero fill
  logic [1:0]   s_axis_tuser  = '0;   // action[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;         // depth_now[7:0], busy[71:8], weighted[135:72]
  logic [1:0]   m_axis_tuser;         // status[1:0]

  // Shadow counters, one entry per category.
  logic [DEPTH_W-1:0] nest_lvl [N_CAT];
  logic [TICK_W-1:0]  last_ts  [N_CAT];
  logic [TICK_W-1:0]  busy_acc [N_CAT];
  logic [TICK_W-1:0]  wgt_acc  [N_CAT];

  activity_evt_t     event_q[$];     // events waiting to be offered
  res_t              report_q[$];    // reports owed by the block, oldest first
  activity_evt_t     cur_evt;
  logic              drain_next = 1'b0;
  logic [TICK_W-1:0] gen_now;
  int                gen_lvl [N_CAT];  // depth the stimulus believes each leaf has
  int                item_total = 0;
  int                events_sent = 0;
  int                reports_seen = 0;
  int                fail_cnt = 0;
  int                cycle_cnt = 0;
  int                tx_gap = 0;
  int                tx_idle_pct = 20;
  bit                tx_offer;
  int                rx_hold = 0;
  int                rx_stall = 0;
  int                rx_idle_pct = 5;
  bit                rx_ready;

  nested_activity_time_accounting_unit #(
    .NUM_CATEGORIES(N_CAT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Apply one event to the shadow counters and return the report it owes.
  // Reject a whole start or stop if any touched entry would leave its range.
  function automatic res_t charge_event(logic [1:0] act, logic [CAT_W-1:0] cat,
                                        logic [TICK_W-1:0] ts);
    res_t              rep;
    int                hit [3];
    int                n_hit;
    int                i;
    int                c;
    logic [TICK_W-1:0] dt;
    rep = '0;
    if (cat >= N_CAT) begin
      rep.status = ST_REFUSED;
      return rep;
    end
    rep.status = ST_OK;
    if (act == ACT_START || act == ACT_STOP) begin
      if (cat == CAT_TOTAL || cat == CAT_UNIV) begin
        rep.status = ST_REFUSED;
      end else begin
        hit[0] = cat;
        n_hit  = 1;
        if (cat < CAT_TOTAL) begin
          hit[n_hit] = CAT_TOTAL;
          n_hit++;
        end
        hit[n_hit] = CAT_UNIV;
        n_hit++;
        for (i = 0; i < n_hit; i++) begin
          if (act == ACT_START && nest_lvl[hit[i]] == DEPTH_MAX) rep.status = ST_OVERFLOW;
          if (act == ACT_STOP && nest_lvl[hit[i]] == '0) rep.status = ST_UNDERFLOW;
        end
        if (rep.status == ST_OK) begin
          for (i = 0; i < n_hit; i++) begin
            c  = hit[i];
            // an idle entry charges nothing, whatever the clock did meanwhile
            dt = (nest_lvl[c] != '0) ? ts - last_ts[c] : '0;
            busy_acc[c] = busy_acc[c] + dt;
            wgt_acc[c]  = wgt_acc[c] + TICK_W'(nest_lvl[c]) * dt;
            last_ts[c]  = ts;
            nest_lvl[c] = (act == ACT_START) ? nest_lvl[c] + 1'b1 : nest_lvl[c] - 1'b1;
          end
        end
      end
    end
    rep.depth = nest_lvl[cat];
    rep.busy  = busy_acc[cat];
    rep.wgt   = wgt_acc[cat];
    return rep;
  endfunction

  function automatic void check_field(string name, logic [TICK_W-1:0] want,
                                      logic [TICK_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic queue_event(logic [1:0] act, logic [CAT_W-1:0] cat,
                             logic [TICK_W-1:0] ts);
    activity_evt_t e;
    e.drain = drain_next;
    e.act   = act;
    e.cat   = cat;
    e.ts    = ts;
    event_q.push_back(e);
    drain_next = 1'b0;
  endtask

  // Advance the free-running clock: mostly small steps, now and then a huge
  // jump, a step backwards or no step at all.
  function automatic logic [TICK_W-1:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      gen_now = gen_now + $urandom_range(0, 2000);
    else if (pick < 92) gen_now = gen_now + {$urandom, $urandom};
    else if (pick < 97) gen_now = gen_now - $urandom_range(1, 500);
    return gen_now;
  endfunction

  function automatic logic [CAT_W-1:0] pick_leaf();
    int c;
    do c = $urandom_range(0, N_CAT - 2); while (c == CAT_TOTAL);
    return CAT_W'(c);
  endfunction

  // Well-formed nesting on leaf categories, with reads mixed in.
  task automatic nest_walk(int len);
    int               i;
    int               roll;
    logic [CAT_W-1:0] c;
    for (i = 0; i < len; i++) begin
      c    = pick_leaf();
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        queue_event(($urandom_range(0, 3) == 0) ? ACT_SPARE : ACT_READ,
                    CAT_W'($urandom_range(0, N_CAT - 1)), next_stamp());
      end else if (gen_lvl[c] >= 8 || (gen_lvl[c] > 0 && roll < 5)) begin
        queue_event(ACT_STOP, c, next_stamp());
        gen_lvl[c]--;
      end else begin
        queue_event(ACT_START, c, next_stamp());
        gen_lvl[c]++;
      end
    end
  endtask

  task automatic unwind_all();
    int c;
    for (c = 0; c < N_CAT - 1; c++) begin
      while (gen_lvl[c] > 0) begin
        queue_event(ACT_STOP, CAT_W'(c), next_stamp());
        gen_lvl[c]--;
      end
    end
  endtask

  // Any action, any index, any timestamp.
  task automatic noise(int len);
    int i;
    for (i = 0; i < len; i++)
      queue_event(2'($urandom_range(0, 3)), CAT_W'($urandom_range(0, 31)),
                  {$urandom, $urandom});
  endtask

  // Close every nest, then push one leaf (and with it total and universal)
  // past the depth ceiling and back below zero.
  task automatic deep_nest();
    int i;
    unwind_all();
    drain_next = 1'b1;
    for (i = 0; i < 258; i++) queue_event(ACT_START, DEEP_CAT, next_stamp());
    queue_event(ACT_READ, CAT_TOTAL, next_stamp());
    queue_event(ACT_READ, CAT_UNIV, next_stamp());
    for (i = 0; i < 260; i++) queue_event(ACT_STOP, DEEP_CAT, next_stamp());
  endtask

  initial begin
    int i;
    int roll;
    int deep_at;
    bit deep_done;
    for (i = 0; i < N_CAT; i++) begin
      nest_lvl[i] = '0;
      last_ts[i]  = '0;
      busy_acc[i] = '0;
      wgt_acc[i]  = '0;
      gen_lvl[i]  = 0;
    end

    // Directed opening.
    queue_event(ACT_READ,  5'd0,      64'd0);      // untouched entry reads zero
    queue_event(ACT_STOP,  5'd0,      64'd3);      // stop with nothing open
    queue_event(ACT_START, CAT_TOTAL, 64'd4);      // aggregates refuse start/stop
    queue_event(ACT_STOP,  CAT_UNIV,  64'd5);
    queue_event(ACT_START, 5'd22,     64'd6);      // first index past the table
    queue_event(ACT_SPARE, 5'd31,     64'd7);
    queue_event(ACT_START, 5'd0,      64'd10);
    queue_event(ACT_START, 5'd0,      64'd20);
    queue_event(ACT_START, 5'd1,      64'd35);
    queue_event(ACT_STOP,  5'd0,      64'd100);
    queue_event(ACT_READ,  CAT_TOTAL, 64'd101);
    queue_event(ACT_SPARE, CAT_UNIV,  64'd102);
    queue_event(ACT_STOP,  5'd0,      64'd90);     // clock steps backwards
    queue_event(ACT_STOP,  5'd1,      64'd150);
    queue_event(ACT_STOP,  5'd1,      64'd160);    // already closed
    queue_event(ACT_START, 5'd20,     64'd0);
    queue_event(ACT_STOP,  5'd20,     '1);         // busy becomes all ones
    queue_event(ACT_START, 5'd20,     64'd5);
    queue_event(ACT_STOP,  5'd20,     64'd10);     // busy wraps
    queue_event(ACT_READ,  5'd20,     '1);

    // Random part: mostly well-formed nesting, some noise, one deep nest.
    gen_now    = 64'd200;
    drain_next = 1'b1;
    deep_at    = $urandom_range(400, 900);
    deep_done  = 1'b0;
    while (event_q.size() < N_EVENTS) begin
      if (!deep_done && event_q.size() >= deep_at) begin
        deep_nest();
        deep_done = 1'b1;
      end
      roll = $urandom_range(0, 19);
      if (roll < 16)      nest_walk($urandom_range(4, 30));
      else if (roll < 19) noise($urandom_range(1, 6));
      else                unwind_all();
      if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
    end
    item_total = event_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (event_q.size() != 0 || s_axis_tvalid || report_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // ------------------------------------------------------------------ driver
  // Predict on the transfer edge, then load the next event unless a gap is
  // running or the head event asks for a full drain first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tx_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(charge_event(cur_evt.act, cur_evt.cat, cur_evt.ts));
        events_sent++;
        tx_offer = 1'b0;
        if (events_sent % 128 == 0) begin
          case ($urandom_range(0, 2))
            0:       tx_idle_pct = 0;
            1:       tx_idle_pct = 20;
            default: tx_idle_pct = 50;
          endcase
        end
        if (events_sent < item_total - TAIL_LEN && $urandom_range(0, 99) < tx_idle_pct)
          tx_gap = $urandom_range(1, 18);
      end
      if (!tx_offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (event_q.size() != 0 && !(event_q[0].drain && report_q.size() != 0)) begin
          cur_evt = event_q.pop_front();
          s_axis_tdata <= {3'b000, cur_evt.ts, cur_evt.cat};
          s_axis_tuser <= cur_evt.act;
          tx_offer = 1'b1;
        end
      end
      s_axis_tvalid <= tx_offer;
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          $error("report with no event outstanding: status %0d depth %0d",
                 m_axis_tuser, m_axis_tdata[7:0]);
          fail_cnt++;
        end else begin
          want = report_q.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("depth_now", want.depth, m_axis_tdata[7:0]);
          check_field("busy_ticks", want.busy, m_axis_tdata[71:8]);
          check_field("weighted_ticks", want.wgt, m_axis_tdata[135:72]);
        end
        // hold off long enough for the block to back up into its input
        if (reports_seen == HOLD_AT) rx_hold = LONG_HOLD;
        if (reports_seen % 128 == 0) begin
          case ($urandom_range(0, 2))
            0:       rx_idle_pct = 0;
            1:       rx_idle_pct = 4;
            default: rx_idle_pct = 12;
          endcase
        end
      end
      if (rx_hold == 0 && rx_stall == 0 && reports_seen < item_total - TAIL_LEN &&
          $urandom_range(0, 99) < rx_idle_pct)
        rx_stall = $urandom_range(1, 18);
      rx_ready = 1'b1;
      if (rx_hold > 0) begin
        rx_hold--;
        rx_ready = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rx_ready = 1'b0;
      end
      m_axis_tready <= rx_ready;
    end
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/nat_pkg.sv
rtl/core/nat_store.sv
rtl/core/nat_alu.sv
rtl/core/nat_seq.sv
rtl/core/nested_activity_time_accounting_unit.sv
dv/tb_nested_activity_time_accounting_unit.sv
